/* sv/rtml_pkg.sv */
`default_nettype none

package rtml_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths.
    localparam int IDX_W      = 4;
    localparam int WORD_W     = 32;
    localparam int CFG_CNT_W  = 5;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 8;

    // Request kinds carried in the input tuser.
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_ENTRIES_IN_USE = 1'b0,
        REG_UNUSED         = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

/* sv/route_table_masked_lookup.sv */
`default_nettype none

// Routing table with a masked match lookup. The table holds TABLE_DEPTH
// (sixteen) pairs of destination and mask in an on-chip memory. A request
// with tuser = 0 writes one pair at entry_index and is acknowledged with a
// result that carries was_lookup = 0; writes to slots beyond the table are
// dropped but still acknowledged. A request with tuser = 1 looks up an IPv4
// address: the entries 0 .. n-1 are read one per cycle through the single
// memory read port and fed to one shared masked comparator, where n is the
// entries_in_use register saturated to the table depth. The result reports
// whether any entry matched and the index of the last matching entry (a later
// entry always wins; this is not a longest-prefix choice). A write, or a
// lookup with n = 0, is answered in the cycle after it is taken. A lookup
// with n > 0 passes through ST_SCAN, which reads the n entries, ST_FINISH,
// which makes the last compare, and ST_OUT, which loads the output register
// once it is free; the next request can be taken only after the return to
// ST_IDLE, so a lookup is finished before another is taken. The input is not
// ready while a lookup is in progress or while the output register holds a
// result that is not being taken. Every entry that a lookup scans must have
// been written since reset; the table is not cleared. entries_in_use sits at
// APB byte address 0 and should only be written while the block is idle.
module route_table_masked_lookup
    import rtml_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // [3:0] entry_index, [35:4] entry_dest, [67:36] entry_mask,
    // [99:68] lookup_addr, [103:100] zero
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  wire logic                   s_axis_tuser,

    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] found, [4:1] match_index, [7:5] zero
    output      logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] was_lookup
    output      logic                   m_axis_tuser,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output      logic [APB_DW-1:0]      prdata,
    output      logic                   pready
);

    // Request fields.
    logic [IDX_W-1:0]  w_entry_index;
    logic [WORD_W-1:0] w_entry_dest;
    logic [WORD_W-1:0] w_entry_mask;
    logic [WORD_W-1:0] w_lookup_addr;
    t_cmd              w_cmd;

    assign w_entry_index = s_axis_tdata[3:0];
    assign w_entry_dest  = s_axis_tdata[35:4];
    assign w_entry_mask  = s_axis_tdata[67:36];
    assign w_lookup_addr = s_axis_tdata[99:68];
    assign w_cmd         = t_cmd'(s_axis_tuser);

    // Route table memory.
    logic [WORD_W-1:0] r_mem_dest [TABLE_DEPTH];
    logic [WORD_W-1:0] r_mem_mask [TABLE_DEPTH];
    logic [WORD_W-1:0] r_rd_dest;
    logic [WORD_W-1:0] r_rd_mask;

    // Control and datapath registers.
    t_state             r_state;
    t_state             n_state;
    logic [CFG_CNT_W-1:0] r_entries;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_rd_idx;
    logic [ADDR_W-1:0]  r_cmp_idx;
    logic               r_cmp_valid;
    logic [WORD_W-1:0]  r_addr;
    logic               r_hit;
    logic [IDX_W-1:0]   r_last;

    logic               r_out_valid;
    logic               r_out_found;
    logic [IDX_W-1:0]   r_out_index;
    logic               r_out_was_lookup;

    // Handshake and sequencing strobes.
    logic               w_out_free;
    logic               w_in_fire;
    logic               w_cfg_wr;
    logic [CNT_W-1:0]   w_scan_n;
    logic               w_scan_last;
    logic               w_rd_en;
    logic               w_mem_wr;
    logic               w_load_now;
    logic               w_load_scan;
    logic               w_match;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready
                        && (t_reg'(paddr[2]) == REG_ENTRIES_IN_USE);

    // Lookups scan at most the whole table.
    assign w_scan_n = (32'(r_entries) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(r_entries);

    assign w_scan_last = (32'(r_rd_idx) + 32'd1) == 32'(r_cnt);

    // The shared comparator: one masked compare per cycle on the read data.
    assign w_match = (r_addr & r_rd_mask) == (r_rd_dest & r_rd_mask);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && (w_cmd == CMD_LOOKUP) && (w_scan_n != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_load_scan   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = w_out_free;
            end
            ST_SCAN: begin
                w_rd_en = 1'b1;
            end
            ST_FINISH: begin
            end
            ST_OUT: begin
                w_load_scan = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Writes, and lookups that scan nothing, are answered at once.
    assign w_load_now = w_in_fire && ((w_cmd == CMD_WRITE) || (w_scan_n == '0));
    assign w_mem_wr   = w_in_fire && (w_cmd == CMD_WRITE)
                        && (32'(w_entry_index) < 32'(TABLE_DEPTH));

    // Table memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_mem_dest[ADDR_W'(w_entry_index)] <= w_entry_dest;
            r_mem_mask[ADDR_W'(w_entry_index)] <= w_entry_mask;
        end
        if (w_rd_en) begin
            r_rd_dest <= r_mem_dest[r_rd_idx];
            r_rd_mask <= r_mem_mask[r_rd_idx];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entries   <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= w_rd_en;
            if (w_cfg_wr) begin
                r_entries <= pwdata[CFG_CNT_W-1:0];
            end
            if (w_load_now || w_load_scan) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan datapath and the output register.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_addr   <= w_lookup_addr;
            r_cnt    <= w_scan_n;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
            r_last   <= '0;
        end else begin
            if (w_rd_en) begin
                r_rd_idx <= r_rd_idx + ADDR_W'(1);
            end
            if (r_cmp_valid && w_match) begin
                r_hit  <= 1'b1;
                r_last <= IDX_W'(r_cmp_idx);
            end
        end
        r_cmp_idx <= r_rd_idx;

        if (w_load_now) begin
            r_out_found      <= 1'b0;
            r_out_index      <= '0;
            r_out_was_lookup <= (w_cmd == CMD_LOOKUP);
        end else if (w_load_scan) begin
            r_out_found      <= r_hit;
            r_out_index      <= r_last;
            r_out_was_lookup <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_index, r_out_found};
    assign m_axis_tuser  = r_out_was_lookup;

    // Register read-back.
    always_comb begin
        prdata = '0;
        if (t_reg'(paddr[2]) == REG_ENTRIES_IN_USE) begin
            prdata = APB_DW'(r_entries);
        end
    end

endmodule

`default_nettype wire
